FILE: sv/spbm_pkg.sv
// shared types and constants for the sparse paged byte memory
`timescale 1ns / 1ps
package spbm_pkg;
    localparam int PAGE_FRAMES_DEF = 16;
    localparam int OFFSET_W = 16;
    localparam int PAGE_W = 48;
    localparam int PAGE_BYTES = 65536;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_WRITE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CLEAR,
        S_RDREQ,
        S_RDWAIT,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic lookup;     // register tag match for current byte address
        logic alloc;      // map page into free frame
        logic unmap;      // clear in-use bit of hit frame
        logic clr_start;  // reset clear counter
        logic clr_step;   // write zero, advance counter
        logic mem_rd;     // issue byte read
        logic mem_wr;     // issue byte write
        logic take_byte;  // merge read byte, advance byte index
        logic set_unmap;  // result status unmapped
        logic set_nospace;
        logic set_wdata;  // result data is written byte
        logic out_load;   // present result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       hit;
        logic       free_avail;
        logic       clr_last;
        logic       last_byte;
        logic       out_busy;
    } sts_t;
endpackage

FILE: sv/spbm_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module spbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: sv/spbm_ctrl.sv
// controller state machine
`timescale 1ns / 1ps
module spbm_ctrl
    import spbm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                // tag match registered on entry; decide here
                unique case (sts.op)
                    OP_CREATE:
                    begin
                        if (sts.hit || sts.free_avail)
                        begin
                            cmd.alloc = !sts.hit;
                            cmd.clr_start = 1'b1;
                            state_next = S_CLEAR;
                        end
                        else
                        begin
                            cmd.set_nospace = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    OP_DESTROY:
                    begin
                        cmd.unmap = sts.hit;
                        state_next = S_DONE;
                    end
                    OP_READ:
                    begin
                        if (sts.hit)
                        begin
                            cmd.mem_rd = 1'b1;
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            cmd.set_unmap = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        if (sts.hit)
                        begin
                            cmd.mem_wr = 1'b1;
                            cmd.set_wdata = 1'b1;
                        end
                        else
                        begin
                            cmd.set_unmap = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_RDWAIT:
            begin
                cmd.take_byte = 1'b1;
                if (sts.last_byte)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.lookup = 1'b1;
                    state_next = S_RDREQ;
                end
            end
            S_RDREQ:
            begin
                if (sts.hit)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_RDWAIT;
                end
                else
                begin
                    cmd.set_unmap = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load)
        else $error("two loads in a row");
    a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == S_IDLE)
        else $error("result without return to idle");
endmodule

FILE: sv/spbm_dp.sv
// datapath: tag table, page store, read assembly, result register
`timescale 1ns / 1ps
module spbm_dp
    import spbm_pkg::*;
#(
    parameter int PAGE_FRAMES = PAGE_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  op,
    input  logic [63:0] address,
    input  logic [7:0]  write_data,
    input  logic [1:0]  read_bytes_log2,
    input  logic        big_endian,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] read_data,
    output logic [1:0]  status
);
    localparam int FW = (PAGE_FRAMES > 1) ? $clog2(PAGE_FRAMES) : 1;
    localparam int DEPTH = PAGE_FRAMES * PAGE_BYTES;
    localparam int AW = $clog2(DEPTH);

    logic [1:0]  op_reg;
    logic [63:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [1:0]  nlog_reg;
    logic        big_reg;
    logic [2:0]  idx_reg;
    logic [63:0] data_reg;
    logic [1:0]  st_reg;
    logic [OFFSET_W-1:0] clr_reg;
    logic        hit_reg;
    logic [FW-1:0] hitf_reg;

    logic [PAGE_W-1:0] pn_reg [PAGE_FRAMES];
    logic [PAGE_FRAMES-1:0] used_reg;

    logic        out_valid_reg;
    logic [63:0] rd_out_reg;
    logic [1:0]  st_out_reg;

    logic [2:0]  look_idx;
    logic [63:0] baddr;
    logic        hit_c;
    logic [FW-1:0] hitf_c;
    logic        free_c;
    logic [FW-1:0] freef_c;
    logic [FW-1:0] frame_sel;
    logic [AW-1:0] ram_addr;
    logic        ram_we;
    logic [7:0]  ram_wd;
    logic [7:0]  ram_rd;
    logic [2:0]  nmax;
    logic [2:0]  sh_idx;

    // next byte is looked up while the current one is merged
    assign look_idx = cmd.take_byte ? 3'(idx_reg + 3'd1) : idx_reg;

    // address of the byte in progress (wraps mod 2^64)
    assign baddr = cmd.load ? address : addr_reg + {61'd0, look_idx};

    always_comb
    begin
        hit_c = 1'b0;
        hitf_c = '0;
        free_c = 1'b0;
        freef_c = '0;
        for (int f = PAGE_FRAMES - 1; f >= 0; f--)
        begin
            if (used_reg[f] && pn_reg[f] == baddr[63:16])
            begin
                hit_c = 1'b1;
                hitf_c = FW'(f);
            end
            if (!used_reg[f])
            begin
                free_c = 1'b1;
                freef_c = FW'(f);
            end
        end
    end

    assign nmax = 3'((4'd1 << nlog_reg) - 4'd1);
    assign sh_idx = big_reg ? 3'(nmax - idx_reg) : idx_reg;

    assign frame_sel = (op_reg == OP_CREATE && !hit_reg) ? freef_c : hitf_reg;
    always_comb
    begin
        ram_we = cmd.clr_step || cmd.mem_wr;
        ram_wd = cmd.clr_step ? 8'd0 : wdata_reg;
        if (cmd.clr_step)
        begin
            ram_addr = AW'({hitf_reg, clr_reg});
        end
        else
        begin
            ram_addr = AW'({hitf_reg, baddr[OFFSET_W-1:0]});
        end
    end

    spbm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wd),
        .rdata(ram_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            addr_reg <= address;
            wdata_reg <= write_data;
            nlog_reg <= read_bytes_log2;
            big_reg <= big_endian;
            idx_reg <= '0;
            data_reg <= '0;
            st_reg <= ST_OK;
        end
        if (cmd.load || cmd.lookup)
        begin
            hit_reg <= hit_c;
            hitf_reg <= hitf_c;
        end
        if (cmd.alloc)
        begin
            hitf_reg <= frame_sel;
        end
        if (cmd.clr_start)
        begin
            clr_reg <= '0;
        end
        if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
        if (cmd.take_byte)
        begin
            data_reg <= data_reg | ({56'd0, ram_rd} << {sh_idx, 3'b000});
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.set_unmap)
        begin
            st_reg <= ST_UNMAPPED;
            data_reg <= '0;
        end
        if (cmd.set_nospace)
        begin
            st_reg <= ST_NO_SPACE;
        end
        if (cmd.set_wdata)
        begin
            data_reg <= {56'd0, wdata_reg};
        end
        if (cmd.out_load)
        begin
            rd_out_reg <= data_reg;
            st_out_reg <= st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int f = 0; f < PAGE_FRAMES; f++)
            begin
                pn_reg[f] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                used_reg[frame_sel] <= 1'b1;
                pn_reg[frame_sel] <= addr_reg[63:16];
            end
            if (cmd.unmap)
            begin
                used_reg[hitf_reg] <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hit registered at load or during the previous byte merge
    assign sts.op = op_reg;
    assign sts.hit = hit_reg;
    assign sts.free_avail = free_c;
    assign sts.clr_last = &clr_reg;
    assign sts.last_byte = idx_reg == nmax;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign read_data = rd_out_reg;
    assign status = st_out_reg;

    a_unmap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_unmap |=> data_reg == 64'd0 && st_reg == ST_UNMAPPED)
        else $error("unmapped result not cleared");
    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !used_reg[frame_sel])
        else $error("allocated a used frame");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(read_data) && $stable(status))
        else $error("result changed while stalled");
endmodule

FILE: sv/sparse_paged_byte_memory.sv
// top level of the sparse paged byte memory
// A 64-bit byte-addressed memory of 64 KiB pages held in PAGE_FRAMES frames.
// One beat in gives one beat out. Create zeroes the frame one byte per cycle
// through the single page-store port, destroy and byte write go from the
// lookup straight to the result, and a read of n bytes needs a tag match and
// a registered page-store read for each byte. The page
// store is undefined after reset; every frame is zeroed on create, so no
// clearing pass runs. A finished result waits in an output register.
`timescale 1ns / 1ps
module sparse_paged_byte_memory
    import spbm_pkg::*;
#(
    parameter int PAGE_FRAMES = PAGE_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [63:0] address,
    input  logic [7:0]  write_data,
    input  logic [1:0]  read_bytes_log2,
    input  logic        big_endian,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] read_data,
    output logic [1:0]  status
);
    cmd_t cmd;
    sts_t sts;

    // sequencer
    spbm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // tag table, page store and result register
    spbm_dp #(.PAGE_FRAMES(PAGE_FRAMES)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .op             (op),
        .address        (address),
        .write_data     (write_data),
        .read_bytes_log2(read_bytes_log2),
        .big_endian     (big_endian),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .status         (status)
    );
endmodule
